/* rtl/rau_pkg.sv */
// Package for the rational arithmetic unit: action codes, widths, controller states,
// and the command and status structs between the controller and the datapath.
// No dependencies.
package rau_pkg;

    localparam int OPERAND_WIDTH_DEF = 16;
    localparam int ACT_W             = 3;
    localparam int RES_NUM_W         = 33;
    localparam int RES_DEN_W         = 31;

    localparam logic [ACT_W-1:0] ACT_ADD = ACT_W'(0);
    localparam logic [ACT_W-1:0] ACT_SUB = ACT_W'(1);
    localparam logic [ACT_W-1:0] ACT_MUL = ACT_W'(2);
    localparam logic [ACT_W-1:0] ACT_DIV = ACT_W'(3);
    localparam logic [ACT_W-1:0] ACT_CMP = ACT_W'(4);

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL_NUM,
        S_MUL_CROSS,
        S_MUL_DEN,
        S_SUM,
        S_ABS,
        S_GCD,
        S_DIV,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        MS_NUM,
        MS_CROSS,
        MS_DEN
    } t_mul_sel;

    typedef struct packed {
        logic     load;
        logic     mul_en;
        t_mul_sel mul_sel;
        logic     sum_en;
        logic     abs_en;
        logic     gcd_step;
        logic     div_init;
        logic     div_step;
        logic     out_load;
    } t_cmd;

    typedef struct packed {
        logic run_gcd;
        logic gcd_done;
    } t_sts;

endpackage

/* rtl/rational_arithmetic_unit_core.sv */
// Top level of the rational arithmetic unit: joins the controller and the datapath.
// Depends on rau_pkg, rau_ctrl and rau_dpath.
//
// Usage: one input beat carries an action and two fractions a_num/a_den and b_num/b_den.
// Add, subtract, multiply and divide return the result reduced to lowest terms with a
// positive denominator; compare returns less, equal and greater with 0/1 as the fraction.
// A zero denominator product raises zero_divide and returns 0/1. One output beat per
// input beat, in order.
// Channels: valid/stall on both sides. i_in_valid with o_in_stall low accepts a beat;
// o_out_valid with i_out_stall low delivers one.
// From accept to o_out_valid every item passes the multiply, sum, abs and done states;
// arithmetic with a nonzero denominator also runs the binary gcd steps and the divider.
// The single gcd subtractor and the bit-serial divider, one quotient bit a cycle over
// 2*OPERAND_WIDTH-1 bits, set how long that takes.
// One item is in work at a time; the next beat is taken once the result has moved
// to the output register, even while that result is still stalled.
// Reset (i_rst_n low, synchronous) drops any item in work and clears o_out_valid.
// A stalled output holds its beat; the block finishes the next item and then waits.
module rational_arithmetic_unit_core #(
    parameter int OPERAND_WIDTH = rau_pkg::OPERAND_WIDTH_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic [rau_pkg::ACT_W-1:0]             i_action,
    input  logic signed [OPERAND_WIDTH-1:0]       i_a_num,
    input  logic [OPERAND_WIDTH-2:0]              i_a_den,
    input  logic signed [OPERAND_WIDTH-1:0]       i_b_num,
    input  logic [OPERAND_WIDTH-2:0]              i_b_den,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic signed [rau_pkg::RES_NUM_W-1:0]  o_res_num,
    output logic [rau_pkg::RES_DEN_W-1:0]         o_res_den,
    output logic                                  o_less,
    output logic                                  o_equal,
    output logic                                  o_greater,
    output logic                                  o_zero_divide
);

    rau_pkg::t_cmd cmd;
    rau_pkg::t_sts sts;

    rau_ctrl #(
        .OPERAND_WIDTH(OPERAND_WIDTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    rau_dpath #(
        .OPERAND_WIDTH(OPERAND_WIDTH)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_action      (i_action),
        .i_a_num       (i_a_num),
        .i_a_den       (i_a_den),
        .i_b_num       (i_b_num),
        .i_b_den       (i_b_den),
        .o_res_num     (o_res_num),
        .o_res_den     (o_res_den),
        .o_less        (o_less),
        .o_equal       (o_equal),
        .o_greater     (o_greater),
        .o_zero_divide (o_zero_divide)
    );

endmodule

/* rtl/rau_ctrl.sv */
// Controller of the rational arithmetic unit: sequencing state machine, divide step counter
// and output valid flag. Depends on rau_pkg.
module rau_ctrl #(
    parameter int OPERAND_WIDTH = rau_pkg::OPERAND_WIDTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    input  rau_pkg::t_sts i_sts,
    output rau_pkg::t_cmd o_cmd
);

    localparam int MW = 2 * OPERAND_WIDTH - 1;
    localparam int CW = $clog2(MW);

    rau_pkg::t_state r_state, n_state;
    logic [CW-1:0]   r_cnt, n_cnt;
    logic            r_out_valid, n_out_valid;
    logic            out_free;
    rau_pkg::t_cmd   cmd;

    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state = r_state;
        case (r_state)
            rau_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = rau_pkg::S_MUL_NUM;
                end
            end
            rau_pkg::S_MUL_NUM:   n_state = rau_pkg::S_MUL_CROSS;
            rau_pkg::S_MUL_CROSS: n_state = rau_pkg::S_MUL_DEN;
            rau_pkg::S_MUL_DEN:   n_state = rau_pkg::S_SUM;
            rau_pkg::S_SUM:       n_state = rau_pkg::S_ABS;
            rau_pkg::S_ABS: begin
                n_state = i_sts.run_gcd ? rau_pkg::S_GCD : rau_pkg::S_DONE;
            end
            rau_pkg::S_GCD: begin
                if (i_sts.gcd_done) begin
                    n_state = rau_pkg::S_DIV;
                end
            end
            rau_pkg::S_DIV: begin
                if (r_cnt == CW'(MW - 1)) begin
                    n_state = rau_pkg::S_DONE;
                end
            end
            rau_pkg::S_DONE: begin
                if (out_free) begin
                    n_state = rau_pkg::S_IDLE;
                end
            end
            default: n_state = rau_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        cmd         = '0;
        cmd.mul_sel = rau_pkg::MS_NUM;
        o_in_stall  = (r_state != rau_pkg::S_IDLE);
        case (r_state)
            rau_pkg::S_IDLE: begin
                cmd.load = i_in_valid;
            end
            rau_pkg::S_MUL_NUM: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = rau_pkg::MS_NUM;
            end
            rau_pkg::S_MUL_CROSS: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = rau_pkg::MS_CROSS;
            end
            rau_pkg::S_MUL_DEN: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = rau_pkg::MS_DEN;
            end
            rau_pkg::S_SUM: begin
                cmd.sum_en = 1'b1;
            end
            rau_pkg::S_ABS: begin
                cmd.abs_en = 1'b1;
            end
            rau_pkg::S_GCD: begin
                cmd.div_init = i_sts.gcd_done;
                cmd.gcd_step = !i_sts.gcd_done;
            end
            rau_pkg::S_DIV: begin
                cmd.div_step = 1'b1;
            end
            rau_pkg::S_DONE: begin
                cmd.out_load = out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

    always_comb begin
        n_cnt = '0;
        if (r_state == rau_pkg::S_DIV) begin
            n_cnt = r_cnt + 1'b1;
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
        if (cmd.out_load) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rau_pkg::S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;

endmodule

/* rtl/rau_dpath.sv */
// Datapath of the rational arithmetic unit: operand registers, shared multiplier,
// sum and sign stage, binary gcd unit, two-lane restoring divider and result register.
// Depends on rau_pkg.
module rau_dpath #(
    parameter int OPERAND_WIDTH = rau_pkg::OPERAND_WIDTH_DEF
) (
    input  logic                                  i_clk,
    input  rau_pkg::t_cmd                         i_cmd,
    output rau_pkg::t_sts                         o_sts,
    input  logic [rau_pkg::ACT_W-1:0]             i_action,
    input  logic signed [OPERAND_WIDTH-1:0]       i_a_num,
    input  logic [OPERAND_WIDTH-2:0]              i_a_den,
    input  logic signed [OPERAND_WIDTH-1:0]       i_b_num,
    input  logic [OPERAND_WIDTH-2:0]              i_b_den,
    output logic signed [rau_pkg::RES_NUM_W-1:0]  o_res_num,
    output logic [rau_pkg::RES_DEN_W-1:0]         o_res_den,
    output logic                                  o_less,
    output logic                                  o_equal,
    output logic                                  o_greater,
    output logic                                  o_zero_divide
);

    localparam int W  = OPERAND_WIDTH;
    localparam int PW = 2 * W;
    localparam int NW = 2 * W + 1;
    localparam int MW = 2 * W - 1;
    localparam int XW = (MW + 1 > rau_pkg::RES_NUM_W) ? MW + 1 : rau_pkg::RES_NUM_W;

    logic [rau_pkg::ACT_W-1:0] r_act;
    logic signed [W-1:0]       r_an, r_bn;
    logic [W-2:0]              r_ad, r_bd;

    logic signed [W-1:0]       opa, opb;
    logic signed [PW-1:0]      prod;
    logic signed [PW-1:0]      r_p1, r_p2, r_p3;

    logic signed [NW-1:0]      sum_n;
    logic signed [PW-1:0]      sel_d;
    logic                      arith, is_cmp;
    logic signed [NW-1:0]      r_n;
    logic signed [PW-1:0]      r_d;
    logic                      r_ok, r_zd, r_lt, r_eq, r_gt;

    logic [NW-1:0]             n_abs;
    logic [PW-1:0]             d_abs;
    logic                      r_neg;

    logic [MW-1:0]             r_u, r_v, r_dn, r_dd;
    logic                      u_ge_v;
    logic [MW-1:0]             diff;

    logic [MW-1:0]             r_qn, r_qd, r_rn, r_rd;
    logic [MW:0]               tn, td, sub_n, sub_d;
    logic                      bit_n, bit_d;

    logic [XW-1:0]             q_num_x, num_x, den_x;

    logic signed [rau_pkg::RES_NUM_W-1:0] r_res_num;
    logic [rau_pkg::RES_DEN_W-1:0]        r_res_den;
    logic                                 r_less, r_equal, r_greater, r_zero_divide;

    always_comb begin
        case (i_cmd.mul_sel)
            rau_pkg::MS_NUM: begin
                opa = r_an;
                opb = (r_act == rau_pkg::ACT_MUL) ? r_bn : $signed({1'b0, r_bd});
            end
            rau_pkg::MS_CROSS: begin
                opa = $signed({1'b0, r_ad});
                opb = r_bn;
            end
            default: begin
                opa = $signed({1'b0, r_ad});
                opb = $signed({1'b0, r_bd});
            end
        endcase
    end

    assign prod = opa * opb;

    always_comb begin
        case (r_act)
            rau_pkg::ACT_ADD: sum_n = NW'(r_p1) + NW'(r_p2);
            rau_pkg::ACT_SUB: sum_n = NW'(r_p1) - NW'(r_p2);
            default:          sum_n = NW'(r_p1);
        endcase
    end

    assign sel_d  = (r_act == rau_pkg::ACT_DIV) ? r_p2 : r_p3;
    assign arith  = r_act inside {rau_pkg::ACT_ADD, rau_pkg::ACT_SUB,
                                  rau_pkg::ACT_MUL, rau_pkg::ACT_DIV};
    assign is_cmp = (r_act == rau_pkg::ACT_CMP);

    assign n_abs = r_n[NW-1] ? -r_n : r_n;
    assign d_abs = r_d[PW-1] ? -r_d : r_d;

    assign u_ge_v = (r_u >= r_v);
    assign diff   = u_ge_v ? (r_u - r_v) : (r_v - r_u);

    assign tn    = {r_rn, r_qn[MW-1]};
    assign td    = {r_rd, r_qd[MW-1]};
    assign sub_n = tn - {1'b0, r_v};
    assign sub_d = td - {1'b0, r_v};
    assign bit_n = !sub_n[MW];
    assign bit_d = !sub_d[MW];

    assign q_num_x = {{(XW - MW){1'b0}}, r_qn};
    assign num_x   = r_neg ? -q_num_x : q_num_x;
    assign den_x   = {{(XW - MW){1'b0}}, r_qd};

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_act <= i_action;
            r_an  <= i_a_num;
            r_ad  <= i_a_den;
            r_bn  <= i_b_num;
            r_bd  <= i_b_den;
        end
        if (i_cmd.mul_en) begin
            case (i_cmd.mul_sel)
                rau_pkg::MS_NUM:   r_p1 <= prod;
                rau_pkg::MS_CROSS: r_p2 <= prod;
                default:           r_p3 <= prod;
            endcase
        end
        if (i_cmd.sum_en) begin
            r_n  <= sum_n;
            r_d  <= sel_d;
            r_ok <= arith && (sel_d != '0);
            r_zd <= arith && (sel_d == '0);
            r_lt <= is_cmp && (r_p1 < r_p2);
            r_eq <= is_cmp && (r_p1 == r_p2);
            r_gt <= is_cmp && (r_p1 > r_p2);
        end
        if (i_cmd.abs_en) begin
            r_u   <= n_abs[MW-1:0];
            r_v   <= d_abs[MW-1:0];
            r_dn  <= n_abs[MW-1:0];
            r_dd  <= d_abs[MW-1:0];
            r_neg <= r_n[NW-1] ^ r_d[PW-1];
        end
        if (i_cmd.gcd_step) begin
            if (!r_u[0] && !r_v[0]) begin
                r_u  <= r_u >> 1;
                r_v  <= r_v >> 1;
                r_dn <= r_dn >> 1;
                r_dd <= r_dd >> 1;
            end else if (!r_u[0]) begin
                r_u <= r_u >> 1;
            end else if (!r_v[0]) begin
                r_v <= r_v >> 1;
            end else if (u_ge_v) begin
                r_u <= diff >> 1;
            end else begin
                r_v <= diff >> 1;
            end
        end
        if (i_cmd.div_init) begin
            r_qn <= r_dn;
            r_qd <= r_dd;
            r_rn <= '0;
            r_rd <= '0;
        end else if (i_cmd.div_step) begin
            r_rn <= bit_n ? sub_n[MW-1:0] : tn[MW-1:0];
            r_rd <= bit_d ? sub_d[MW-1:0] : td[MW-1:0];
            r_qn <= {r_qn[MW-2:0], bit_n};
            r_qd <= {r_qd[MW-2:0], bit_d};
        end
        if (i_cmd.out_load) begin
            r_res_num     <= r_ok ? num_x[rau_pkg::RES_NUM_W-1:0] : '0;
            r_res_den     <= r_ok ? den_x[rau_pkg::RES_DEN_W-1:0] : rau_pkg::RES_DEN_W'(1);
            r_less        <= r_lt;
            r_equal       <= r_eq;
            r_greater     <= r_gt;
            r_zero_divide <= r_zd;
        end
    end

    assign o_sts.run_gcd  = r_ok;
    assign o_sts.gcd_done = (r_u == '0);

    assign o_res_num     = r_res_num;
    assign o_res_den     = r_res_den;
    assign o_less        = r_less;
    assign o_equal       = r_equal;
    assign o_greater     = r_greater;
    assign o_zero_divide = r_zero_divide;

endmodule

/* rtl/rau_checker.sv */
// Port-level checks for the rational arithmetic unit, bound to the top level.
// Depends on rau_pkg and rational_arithmetic_unit_core.
module rau_checker (
    input logic                                  i_clk,
    input logic                                  i_rst_n,
    input logic                                  i_in_valid,
    input logic                                  o_in_stall,
    input logic                                  o_out_valid,
    input logic                                  i_out_stall,
    input logic signed [rau_pkg::RES_NUM_W-1:0]  o_res_num,
    input logic [rau_pkg::RES_DEN_W-1:0]         o_res_den,
    input logic                                  o_less,
    input logic                                  o_equal,
    input logic                                  o_greater,
    input logic                                  o_zero_divide
);

    a_out_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("output beat dropped while stalled");

    a_out_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_res_num) && $stable(o_res_den)
            && $stable(o_less) && $stable(o_equal) && $stable(o_greater)
            && $stable(o_zero_divide))
        else $error("stalled output beat changed");

    a_one_in_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second beat taken while an item is in work");

    a_zero_divide_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_zero_divide |-> o_res_num == '0
            && o_res_den == rau_pkg::RES_DEN_W'(1)
            && !o_less && !o_equal && !o_greater)
        else $error("zero divide beat without 0/1 result");

    a_compare_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> $countones({o_less, o_equal, o_greater}) <= 1)
        else $error("more than one compare flag set");

endmodule

bind rational_arithmetic_unit_core rau_checker u_rau_checker (.*);

/* bench/rational_arithmetic_unit_core_test.sv */
// Self-checking bench for rational_arithmetic_unit_core: directed and random fraction beats,
// a predictor that reduces each result in lowest terms, and a scoreboard on the output.
// Depends on rau_pkg and the rational_arithmetic_unit_core RTL.
`timescale 1ns / 1ps

module rational_arithmetic_unit_core_test;

    localparam int OW = rau_pkg::OPERAND_WIDTH_DEF;
    localparam int AW = rau_pkg::ACT_W;
    localparam int NRW = rau_pkg::RES_NUM_W;
    localparam int DRW = rau_pkg::RES_DEN_W;
    localparam logic [AW-1:0] ACT_SPARE = rau_pkg::ACT_CMP + AW'(1);

    typedef struct {
        logic [AW-1:0]          action;
        logic signed [OW-1:0]   a_num;
        logic [OW-2:0]          a_den;
        logic signed [OW-1:0]   b_num;
        logic [OW-2:0]          b_den;
        int                     gap;
        bit                     drain;
    } t_operand_beat;

    typedef struct {
        logic signed [NRW-1:0] res_num;
        logic [DRW-1:0]        res_den;
        logic                  less;
        logic                  equal;
        logic                  greater;
        logic                  zero_divide;
    } t_fraction_result;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    logic [AW-1:0]         i_action = rau_pkg::ACT_ADD;
    logic signed [OW-1:0]  i_a_num = '0;
    logic [OW-2:0]         i_a_den = '0;
    logic signed [OW-1:0]  i_b_num = '0;
    logic [OW-2:0]         i_b_den = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic signed [NRW-1:0] o_res_num;
    logic [DRW-1:0]        o_res_den;
    logic                  o_less;
    logic                  o_equal;
    logic                  o_greater;
    logic                  o_zero_divide;

    t_operand_beat    operand_beats[$];
    t_fraction_result reduced_results[$];

    bit offering = 0;
    bit in_taken = 0;
    bit out_taken = 0;
    bit gap_armed = 0;
    bit hold_off = 0;
    int gap_left = 0;
    int stall_left = 0;
    int accepted = 0;
    int delivered = 0;
    int mismatches = 0;
    int compares = 0;
    int zero_divides = 0;
    int spares = 0;

    rational_arithmetic_unit_core u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_action      (i_action),
        .i_a_num       (i_a_num),
        .i_a_den       (i_a_den),
        .i_b_num       (i_b_num),
        .i_b_den       (i_b_den),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_res_num     (o_res_num),
        .o_res_den     (o_res_den),
        .o_less        (o_less),
        .o_equal       (o_equal),
        .o_greater     (o_greater),
        .o_zero_divide (o_zero_divide)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic t_fraction_result rational_result(
        logic [AW-1:0] action, logic signed [OW-1:0] a_num, logic [OW-2:0] a_den,
        logic signed [OW-1:0] b_num, logic [OW-2:0] b_den);
        longint an, ad, bn, bd, n, d, p, q, t;
        t_fraction_result res;
        an = longint'(a_num);
        ad = longint'(a_den);
        bn = longint'(b_num);
        bd = longint'(b_den);
        n = 0;
        d = 1;
        res.less = 1'b0;
        res.equal = 1'b0;
        res.greater = 1'b0;
        res.zero_divide = 1'b0;
        case (action)
            rau_pkg::ACT_ADD: begin
                n = an * bd + ad * bn;
                d = ad * bd;
            end
            rau_pkg::ACT_SUB: begin
                n = an * bd - ad * bn;
                d = ad * bd;
            end
            rau_pkg::ACT_MUL: begin
                n = an * bn;
                d = ad * bd;
            end
            rau_pkg::ACT_DIV: begin
                n = an * bd;
                d = ad * bn;
            end
            rau_pkg::ACT_CMP: begin
                res.less    = (an * bd) <  (ad * bn);
                res.equal   = (an * bd) == (ad * bn);
                res.greater = (an * bd) >  (ad * bn);
            end
            default: ;
        endcase
        if (action <= rau_pkg::ACT_DIV) begin
            if (d == 0) begin
                res.zero_divide = 1'b1;
                n = 0;
                d = 1;
            end else begin
                if (d < 0) begin
                    d = -d;
                    n = -n;
                end
                p = (n < 0) ? -n : n;
                q = d;
                while (q != 0) begin
                    t = p % q;
                    p = q;
                    q = t;
                end
                if (p > 1) begin
                    n = n / p;
                    d = d / p;
                end
            end
        end
        res.res_num = n[NRW-1:0];
        res.res_den = d[DRW-1:0];
        return res;
    endfunction

    function automatic logic signed [OW-1:0] pick_num();
        int r;
        r = $urandom_range(0, 65535);
        case ($urandom_range(0, 5))
            0: r = $urandom_range(0, 16) - 8;
            1: begin
                case ($urandom_range(0, 5))
                    0: r = -32768;
                    1: r = -32767;
                    2: r = -1;
                    3: r = 0;
                    4: r = 1;
                    default: r = 32767;
                endcase
            end
            default: ;
        endcase
        return r[OW-1:0];
    endfunction

    function automatic logic [OW-2:0] pick_den();
        int r;
        r = $urandom_range(0, 32767);
        case ($urandom_range(0, 19))
            0: r = 0;
            1, 2, 3, 4: r = $urandom_range(1, 8);
            5: r = 1;
            6: r = 32767;
            default: ;
        endcase
        return r[OW-2:0];
    endfunction

    task automatic queue_beat(logic [AW-1:0] action, int an, int ad, int bn, int bd,
                              int gap, bit drain);
        t_operand_beat b;
        b.action = action;
        b.a_num  = an[OW-1:0];
        b.a_den  = ad[OW-2:0];
        b.b_num  = bn[OW-1:0];
        b.b_den  = bd[OW-2:0];
        b.gap    = gap;
        b.drain  = drain;
        operand_beats.push_back(b);
    endtask

    // driver: present one beat at a time, hold it until taken
    always @(negedge i_clk) begin
        t_operand_beat b;
        if (i_rst_n) begin
            if (in_taken) begin
                in_taken = 0;
                offering = 0;
            end
            if (!offering && operand_beats.size() > 0) begin
                if (!gap_armed) begin
                    gap_left = operand_beats[0].gap;
                    gap_armed = 1;
                end
                if (gap_left > 0) begin
                    gap_left--;
                end else if (!operand_beats[0].drain || reduced_results.size() == 0) begin
                    b = operand_beats.pop_front();
                    gap_armed = 0;
                    offering = 1;
                    i_action <= b.action;
                    i_a_num  <= b.a_num;
                    i_a_den  <= b.a_den;
                    i_b_num  <= b.b_num;
                    i_b_den  <= b.b_den;
                end
            end
            i_in_valid <= offering;
        end
    end

    // receiver stall: random wait per result, calm stretches, plus the long hold-off
    always @(negedge i_clk) begin
        bit stall_now;
        if (out_taken) begin
            out_taken = 0;
            stall_left = ((delivered / 90) % 3 == 1) ? 0 : $urandom_range(0, 16);
        end
        stall_now = stall_left > 0;
        if (stall_now)
            stall_left--;
        i_out_stall <= stall_now || hold_off;
    end

    // monitor: check delivered beats, predict accepted ones
    always @(posedge i_clk) begin
        t_fraction_result want;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                out_taken = 1;
                delivered++;
                if (reduced_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result beat: %0d/%0d", o_res_num, o_res_den);
                end else begin
                    want = reduced_results.pop_front();
                    if (o_res_num !== want.res_num || o_res_den !== want.res_den ||
                        o_less !== want.less || o_equal !== want.equal ||
                        o_greater !== want.greater || o_zero_divide !== want.zero_divide) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("result %0d: expected %0d/%0d lt%b eq%b gt%b zd%b",
                                     delivered, want.res_num, want.res_den, want.less,
                                     want.equal, want.greater, want.zero_divide);
                            $display("result %0d: got      %0d/%0d lt%b eq%b gt%b zd%b",
                                     delivered, o_res_num, o_res_den, o_less, o_equal,
                                     o_greater, o_zero_divide);
                        end
                    end
                end
            end
            if (i_in_valid && !o_in_stall) begin
                want = rational_result(i_action, i_a_num, i_a_den, i_b_num, i_b_den);
                reduced_results.push_back(want);
                in_taken = 1;
                accepted++;
                if (i_action == rau_pkg::ACT_CMP)
                    compares++;
                if (i_action > rau_pkg::ACT_CMP)
                    spares++;
                if (want.zero_divide)
                    zero_divides++;
            end
        end
    end

    // long receiver hold-off while the sender keeps offering
    initial begin
        wait (accepted >= 450);
        @(negedge i_clk);
        hold_off <= 1'b1;
        repeat (400) @(negedge i_clk);
        hold_off <= 1'b0;
    end

    initial begin
        #20_000_000;
        $display("[rational_arithmetic_unit_core] ERROR");
        $finish;
    end

    initial begin
        int gap;
        logic [AW-1:0] act;
        queue_beat(rau_pkg::ACT_ADD, 1, 2, 1, 3, 0, 0);
        queue_beat(rau_pkg::ACT_SUB, 1, 2, 1, 2, 0, 0);
        queue_beat(rau_pkg::ACT_MUL, -32768, 1, -32768, 1, 3, 0);
        queue_beat(rau_pkg::ACT_DIV, 1, 1, 0, 5, 0, 0);
        queue_beat(rau_pkg::ACT_DIV, 3, 4, -3, 8, 5, 0);
        queue_beat(rau_pkg::ACT_CMP, 1, 2, 2, 4, 0, 0);
        queue_beat(rau_pkg::ACT_CMP, -1, 3, 1, 3, 1, 0);
        queue_beat(rau_pkg::ACT_CMP, 32767, 1, -32768, 32767, 0, 0);
        queue_beat(rau_pkg::ACT_ADD, 32767, 32767, 32767, 32767, 0, 0);
        queue_beat(rau_pkg::ACT_ADD, -32768, 32767, -32768, 32767, 2, 0);
        queue_beat(rau_pkg::ACT_SUB, 32767, 1, -32768, 1, 0, 0);
        queue_beat(rau_pkg::ACT_SUB, -32768, 1, 32767, 32767, 0, 0);
        queue_beat(rau_pkg::ACT_ADD, 5, 0, 3, 7, 0, 0);
        queue_beat(rau_pkg::ACT_MUL, 5, 3, 3, 0, 0, 0);
        queue_beat(rau_pkg::ACT_DIV, 4, 0, 7, 9, 0, 0);
        queue_beat(rau_pkg::ACT_CMP, 6, 0, -2, 0, 4, 0);
        queue_beat(ACT_SPARE, 9, 4, 7, 3, 0, 0);
        queue_beat(ACT_SPARE + AW'(1), -1, 32767, -1, 32767, 0, 0);
        queue_beat(ACT_SPARE + AW'(2), -32768, 0, 32767, 0, 0, 0);
        queue_beat(rau_pkg::ACT_MUL, 0, 1, -5, 7, 0, 0);
        queue_beat(rau_pkg::ACT_DIV, -32768, 1, -32768, 32767, 0, 0);
        queue_beat(rau_pkg::ACT_MUL, -32768, 32767, 32767, 32767, 0, 0);
        queue_beat(rau_pkg::ACT_ADD, -1, 32767, -1, 32767, 0, 0);
        queue_beat(rau_pkg::ACT_DIV, 0, 5, 7, 3, 0, 0);
        for (int i = 0; i < 750; i++) begin
            gap = ((i / 120) % 3 == 2) ? 0 : $urandom_range(0, 16);
            if ($urandom_range(0, 9) < 8)
                act = AW'($urandom_range(rau_pkg::ACT_ADD, rau_pkg::ACT_CMP));
            else
                act = AW'($urandom_range(0, (1 << AW) - 1));
            queue_beat(act, pick_num(), pick_den(), pick_num(), pick_den(), gap, i == 300);
        end

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (operand_beats.size() > 0 || offering || reduced_results.size() > 0)
            @(posedge i_clk);
        repeat (200) @(posedge i_clk);

        $display("%0d beats in, %0d results out: %0d compares, %0d zero divides, %0d spare codes",
                 accepted, delivered, compares, zero_divides, spares);
        $display("%0d mismatches", mismatches);
        if (mismatches == 0 && reduced_results.size() == 0)
            $display("[rational_arithmetic_unit_core] OK");
        else
            $display("[rational_arithmetic_unit_core] ERROR");
        $finish;
    end

endmodule
